// ===== hw/rtl/blfr_pkg.sv =====
`timescale 1ns / 1ps

package blfr_pkg;

   localparam int REQ_W   = 2;
   localparam int IDX_W   = 9;
   localparam int CNT_W   = 10;
   localparam int START_W = 9;
   localparam int WORD_W  = 64;
   localparam int BYTE_W  = 8;
   localparam int BSEL_W  = 3;
   localparam int BOFF_W  = 6;

   localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage

// ===== hw/rtl/blfr_map_mem.sv =====
`timescale 1ns / 1ps

module blfr_map_mem #(
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [blfr_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [blfr_pkg::WORD_W-1:0] rd_data
);
   import blfr_pkg::*;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   // an entry never written since reset reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== hw/rtl/blfr_scan.sv =====
`timescale 1ns / 1ps

module blfr_scan #(
   parameter int MAP_BITS = 512,
   localparam int MAP_WORDS = (MAP_BITS + 63) / 64,
   localparam int CW = $clog2(MAP_BITS + 1),
   localparam int PW = $clog2(MAP_WORDS * 64)
) (
   input  logic                       clock,
   input  blfr_pkg::scan_ctl_type     ctl,
   input  logic [blfr_pkg::BYTE_W-1:0] byte_data,
   input  logic [PW-1:0]              base_pos,
   output logic [CW-1:0]              used_count,
   output logic [CW-1:0]              run_len,
   output logic [PW-1:0]              run_start
);
   import blfr_pkg::*;

   logic [CW-1:0] cur_len_ff, cur_len_in;
   logic [PW-1:0] cur_start_ff, cur_start_in;
   logic [CW-1:0] best_len_ff, best_len_in;
   logic [PW-1:0] best_start_ff, best_start_in;
   logic [CW-1:0] used_ff, used_in;

   // walk the byte from its high bit down; a longer run replaces the best,
   // a tie keeps the higher one; bits past the map end act as used
   always_comb begin
      logic [PW-1:0] pos;
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      used_in       = used_ff;
      pos           = base_pos;
      for (int j = BYTE_W - 1; j >= 0; j--) begin
         pos     = base_pos | PW'(j);
         used_in = used_in + CW'(byte_data[j]);
         if (!byte_data[j] && (CW'(pos) < CW'(MAP_BITS))) begin
            cur_len_in   = cur_len_in + CW'(1);
            cur_start_in = pos;
         end else begin
            if (cur_len_in > best_len_in) begin
               best_len_in   = cur_len_in;
               best_start_in = cur_start_in;
            end
            cur_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         cur_len_ff    <= '0;
         cur_start_ff  <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         used_ff       <= '0;
      end else if (ctl.step) begin
         cur_len_ff    <= cur_len_in;
         cur_start_ff  <= cur_start_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         used_ff       <= used_in;
      end
   end

   // close the run that reaches index 0
   assign used_count = used_ff;
   assign run_len    = (cur_len_ff > best_len_ff) ? cur_len_ff : best_len_ff;
   assign run_start  = (cur_len_ff > best_len_ff) ? cur_start_ff : best_start_ff;

endmodule

// ===== hw/rtl/bitmap_longest_free_run.sv =====
`timescale 1ns / 1ps

// Allocation map of MAP_BITS bits (1 = used, 0 = free) with a report of the
// used count and the longest free run after every item.
// Input channel: an item (req_type, req_bit_index) is taken at a rising edge
// with start high and busy low. req_type marks the bit used, marks it free,
// or only reports; an index at or past MAP_BITS leaves the map as it is.
// Result channel: rsp_valid is high for one cycle with rsp_used_count,
// rsp_longest_free_len and rsp_longest_free_start; the receiver cannot
// stall, so results are never held back.
// Steps: an in-range set or clear first passes ST_UPD; every item then passes
// ST_SCAN_RD, ST_SCAN over the bytes of the map words and ST_DONE before
// rsp_valid. busy drops in the rsp_valid cycle, so the next item may be taken
// there; one item is worked on at a time.
// The scan reads one map word from the memory port and consumes one byte of
// it per cycle, high index first.
// Reset: the map reads as all free at once through per-word written flags;
// there is no clearing pass.
module bitmap_longest_free_run #(
   parameter int MAP_BITS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [blfr_pkg::REQ_W-1:0]   req_type,
   input  logic [blfr_pkg::IDX_W-1:0]   req_bit_index,
   output logic                         rsp_valid,
   output logic [blfr_pkg::CNT_W-1:0]   rsp_used_count,
   output logic [blfr_pkg::CNT_W-1:0]   rsp_longest_free_len,
   output logic [blfr_pkg::START_W-1:0] rsp_longest_free_start
);
   import blfr_pkg::*;

   localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
   localparam int WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW  = $clog2(MAP_BITS + 1);
   localparam int PW  = $clog2(MAP_WORDS * 64);
   localparam int IW  = (IDX_W > CW) ? IDX_W : CW;
   localparam logic [WAW-1:0] TOP_WORD = WAW'(MAP_WORDS - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UPD     = 3'd1;
   localparam logic [2:0] ST_SCAN_RD = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_DONE    = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [REQ_W-1:0]  type_ff;
   logic [BOFF_W-1:0] bit_off_ff;
   logic [WAW-1:0]    upd_word_ff;
   logic [WAW-1:0]    word_ptr_ff, word_ptr_in;
   logic [BSEL_W-1:0] byte_ptr_ff, byte_ptr_in;
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  len_ff;
   logic [START_W-1:0] start_ff;

   logic              accept;
   logic              do_update;
   logic              rd_en;
   logic [WAW-1:0]    rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] bit_mask;
   logic              last_byte;
   scan_ctl_type      scan_ctl;
   logic [PW-1:0]     base_pos;
   logic [CW-1:0]     scan_used;
   logic [CW-1:0]     scan_len;
   logic [PW-1:0]     scan_start;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign do_update = ((req_type == REQ_SET) || (req_type == REQ_CLEAR)) &&
                      (IW'(req_bit_index) < IW'(MAP_BITS));
   assign last_byte = (byte_ptr_ff == '0);

   assign bit_mask = WORD_W'(1) << bit_off_ff;
   assign wr_en    = (state_ff == ST_UPD);
   assign wr_data  = (type_ff == REQ_SET) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

   always_comb begin
      state_in       = state_ff;
      word_ptr_in    = word_ptr_ff;
      byte_ptr_in    = byte_ptr_ff;
      rd_en          = 1'b0;
      rd_addr        = word_ptr_ff;
      scan_ctl.clear = 1'b0;
      scan_ctl.step  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_en    = 1'b1;
               rd_addr  = WAW'(req_bit_index >> BOFF_W);
               state_in = do_update ? ST_UPD : ST_SCAN_RD;
            end
         end
         ST_UPD: begin
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            // the write of the update lands before this read
            rd_en          = 1'b1;
            rd_addr        = TOP_WORD;
            word_ptr_in    = TOP_WORD;
            byte_ptr_in    = '1;
            scan_ctl.clear = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            scan_ctl.step = 1'b1;
            byte_ptr_in   = byte_ptr_ff - 1'b1;
            if (last_byte) begin
               if (word_ptr_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  // fetch the next word down; it arrives as this byte retires
                  rd_en       = 1'b1;
                  rd_addr     = word_ptr_ff - 1'b1;
                  word_ptr_in = word_ptr_ff - 1'b1;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      word_ptr_ff <= word_ptr_in;
      byte_ptr_ff <= byte_ptr_in;
      if (accept) begin
         type_ff     <= req_type;
         bit_off_ff  <= req_bit_index[BOFF_W-1:0];
         upd_word_ff <= WAW'(req_bit_index >> BOFF_W);
      end
      if (state_ff == ST_DONE) begin
         used_ff  <= CNT_W'(scan_used);
         len_ff   <= CNT_W'(scan_len);
         start_ff <= START_W'(scan_start);
      end
   end

   assign base_pos = PW'({word_ptr_ff, byte_ptr_ff, 3'b000});

   blfr_map_mem #(
      .DEPTH (MAP_WORDS)
   ) u_map_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (upd_word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   blfr_scan #(
      .MAP_BITS (MAP_BITS)
   ) u_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .byte_data  (rd_data[byte_ptr_ff * BYTE_W +: BYTE_W]),
      .base_pos   (base_pos),
      .used_count (scan_used),
      .run_len    (scan_len),
      .run_start  (scan_start)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_used_count         = used_ff;
   assign rsp_longest_free_len   = len_ff;
   assign rsp_longest_free_start = start_ff;

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("result strobe without a finished scan");

   a_write_only_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> $past(state_ff == ST_IDLE) && $past(accept))
      else $error("map write outside the update step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepting an item");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && last_byte && (word_ptr_ff == '0) |=> state_ff == ST_DONE)
      else $error("scan did not finish after the lowest byte");

endmodule

// ===== tb/tb_bitmap_longest_free_run.sv =====
`timescale 1ns / 1ps

module tb_bitmap_longest_free_run;
   import blfr_pkg::*;

   localparam int MAP_BITS  = 512;
   localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int LIMIT     = 1000000;
   localparam int DRAIN     = 80;

   // code 3 is unused by the block and behaves as a report
   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

   typedef struct {
      logic [CNT_W-1:0]   used;
      logic [CNT_W-1:0]   run_len;
      logic [START_W-1:0] run_start;
   } map_report_type;

   class free_run_scoreboard;
      logic [WORD_W-1:0] map_words [MAP_WORDS];
      map_report_type    expected_reports [$];
      int                mismatches;
      int                items_seen;
      int                reports_checked;
      int                full_seen;
      int                empty_seen;

      function new();
         foreach (map_words[w]) map_words[w] = '0;
         mismatches = 0;
         items_seen = 0;
         reports_checked = 0;
         full_seen = 0;
         empty_seen = 0;
      endfunction

      function bit bit_used(int idx);
         return map_words[idx / WORD_W][idx % WORD_W];
      endfunction

      // apply the update, then scan high index to low; a tie keeps the higher run
      function void note_item(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx);
         map_report_type rep;
         int             used;
         int             cur_len;
         int             cur_start;
         int             best_len;
         int             best_start;
         items_seen++;
         if (int'(idx) < MAP_BITS) begin
            case (kind)
               REQ_SET:   map_words[idx / WORD_W][idx % WORD_W] = 1'b1;
               REQ_CLEAR: map_words[idx / WORD_W][idx % WORD_W] = 1'b0;
               default: ;
            endcase
         end
         used = 0;
         cur_len = 0;
         cur_start = 0;
         best_len = 0;
         best_start = 0;
         for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (!bit_used(i)) begin
               cur_len++;
               cur_start = i;
            end else begin
               used++;
               if (cur_len > best_len) begin
                  best_len = cur_len;
                  best_start = cur_start;
               end
               cur_len = 0;
            end
         end
         if (cur_len > best_len) begin
            best_len = cur_len;
            best_start = cur_start;
         end
         if (used == MAP_BITS) full_seen++;
         if (used == 0) empty_seen++;
         rep.used = CNT_W'(used);
         rep.run_len = CNT_W'(best_len);
         rep.run_start = START_W'(best_start);
         expected_reports.push_back(rep);
      endfunction

      function void check_result(logic [CNT_W-1:0] used, logic [CNT_W-1:0] run_len,
                                 logic [START_W-1:0] run_start);
         map_report_type want;
         if (expected_reports.size() == 0) begin
            $error("report with no item outstanding: used %0d len %0d start %0d",
                   used, run_len, run_start);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         reports_checked++;
         if (used !== want.used) begin
            $error("used_count: expected %0d, got %0d", want.used, used);
            mismatches++;
         end
         if (run_len !== want.run_len) begin
            $error("longest_free_len: expected %0d, got %0d", want.run_len, run_len);
            mismatches++;
         end
         if (run_start !== want.run_start) begin
            $error("longest_free_start: expected %0d, got %0d", want.run_start, run_start);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [REQ_W-1:0]   req_type;
   logic [IDX_W-1:0]   req_bit_index;
   logic               rsp_valid;
   logic [CNT_W-1:0]   rsp_used_count;
   logic [CNT_W-1:0]   rsp_longest_free_len;
   logic [START_W-1:0] rsp_longest_free_start;

   free_run_scoreboard board;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   int                 order [MAP_BITS];

   bitmap_longest_free_run #(
      .MAP_BITS(MAP_BITS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_bit_index         (req_bit_index),
      .rsp_valid             (rsp_valid),
      .rsp_used_count        (rsp_used_count),
      .rsp_longest_free_len  (rsp_longest_free_len),
      .rsp_longest_free_start(rsp_longest_free_start)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check the result first: the next item may be taken on the same edge
   always @(posedge clock) begin
      if (!reset && board != null) begin
         if (rsp_valid)
            board.check_result(rsp_used_count, rsp_longest_free_len, rsp_longest_free_start);
         if (start && !busy)
            board.note_item(req_type, req_bit_index);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $error("timeout after %0d cycles", LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // present one item, with a random gap first whenever a burst runs out
   task automatic issue(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx);
      int gap_len;
      if (burst_left == 0) begin
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
         repeat (gap_len) begin
            @(negedge clock);
            start <= 1'b0;
            req_type <= REQ_W'($urandom);
            req_bit_index <= IDX_W'($urandom);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_bit_index <= idx;
      do @(posedge clock); while (busy);
   endtask

   task automatic shuffle_order();
      int j;
      int tmp;
      foreach (order[i]) order[i] = i;
      for (int i = MAP_BITS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
   endtask

   // walk every index once with one operation, slipping in a few reports
   task automatic sweep(logic [REQ_W-1:0] kind);
      shuffle_order();
      foreach (order[i]) begin
         if ($urandom_range(0, 15) == 0)
            issue(($urandom_range(0, 1) == 0) ? REQ_REPORT : REQ_SPARE, IDX_W'($urandom));
         issue(kind, IDX_W'(order[i]));
      end
   endtask

   // random traffic clustered in windows so that runs form and break
   task automatic run_mixed(int count);
      int base;
      int width;
      int roll;
      logic [REQ_W-1:0] kind;
      base = 0;
      width = MAP_BITS;
      for (int n = 0; n < count; n++) begin
         if (n % 20 == 0) begin
            base = $urandom_range(0, MAP_BITS - 1);
            width = 1 << $urandom_range(0, 9);
         end
         roll = $urandom_range(0, 99);
         if (roll < 45) kind = REQ_SET;
         else if (roll < 85) kind = REQ_CLEAR;
         else if (roll < 95) kind = REQ_REPORT;
         else kind = REQ_SPARE;
         issue(kind, IDX_W'((base + $urandom_range(0, width - 1)) % MAP_BITS));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_REPORT;
      req_bit_index = '0;
      board = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty map, spare code, both ends, a center split and a tie
      issue(REQ_REPORT, 9'd0);
      issue(REQ_SPARE, 9'd511);
      issue(REQ_SET, 9'd0);
      issue(REQ_SET, 9'd511);
      issue(REQ_SET, 9'd255);
      issue(REQ_SET, 9'd256);
      issue(REQ_SET, 9'd63);
      issue(REQ_SET, 9'd64);
      issue(REQ_SET, 9'd64);
      issue(REQ_REPORT, 9'd511);
      issue(REQ_CLEAR, 9'd300);
      issue(REQ_CLEAR, 9'd511);
      issue(REQ_CLEAR, 9'd0);
      issue(REQ_SPARE, 9'd0);
      issue(REQ_CLEAR, 9'd63);
      issue(REQ_CLEAR, 9'd64);
      issue(REQ_CLEAR, 9'd255);
      issue(REQ_CLEAR, 9'd256);
      issue(REQ_SET, 9'd448);
      issue(REQ_SET, 9'd383);
      issue(REQ_CLEAR, 9'd448);
      issue(REQ_CLEAR, 9'd383);

      sweep(REQ_SET);
      run_mixed(340);
      sweep(REQ_CLEAR);
      run_mixed(380);

      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (board.pending() != 0)
         $error("%0d reports never arrived", board.pending());
      $display("Sent %0d items and checked %0d reports, including set/clear sweeps",
               board.items_seen, board.reports_checked);
      $display("Map seen full %0d times and empty %0d times; %0d mismatches",
               board.full_seen, board.empty_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
